/* design/lhbp_pkg.sv */
package lhbp_pkg;

  // table geometry
  localparam int HISTORY_BITS  = 14;
  localparam int COUNTER_WIDTH = 2;
  localparam int INDEX_BITS    = 10;

  // fixed field widths
  localparam int ADDR_W   = 10;
  localparam int THRESH_W = 2;

  // clear sweep covers the larger of the two tables
  localparam int CLR_BITS = (HISTORY_BITS > INDEX_BITS) ? HISTORY_BITS : INDEX_BITS;
  // comparison width for counter against threshold
  localparam int CMP_W = (COUNTER_WIDTH > THRESH_W) ? COUNTER_WIDTH : THRESH_W;

  localparam logic [COUNTER_WIDTH-1:0] CTR_MAX = '1;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(1);

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [INDEX_BITS-1:0]    slot_t;
  typedef logic [HISTORY_BITS-1:0]  hist_t;
  typedef logic [COUNTER_WIDTH-1:0] ctr_t;
  typedef logic [THRESH_W-1:0]      thresh_t;
  typedef logic [CLR_BITS-1:0]      clr_t;

  typedef enum logic [0:0] {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_PAT
  } state_t;

  // history table port request
  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  wr_en;
    slot_t wr_addr;
    hist_t wr_data;
  } hist_req_t;

  // pattern table port request
  typedef struct packed {
    logic  rd_en;
    hist_t rd_addr;
    logic  wr_en;
    hist_t wr_addr;
    ctr_t  wr_data;
  } pat_req_t;

  // table index from the low address bits
  function automatic slot_t slot_of(input addr_t addr);
    slot_of = INDEX_BITS'(addr);
  endfunction

  // saturating counter step
  function automatic ctr_t ctr_step(input ctr_t ctr, input logic tk);
    ctr_t r;
    r = ctr;
    if (tk) begin
      if (ctr != CTR_MAX) r = ctr + ctr_t'(1);
    end else begin
      if (ctr != ctr_t'(0)) r = ctr - ctr_t'(1);
    end
    ctr_step = r;
  endfunction

endpackage

/* design/lhbp_ifs.sv */
// request channel: predict or update
interface lhbp_req_if;
  logic                 valid;
  logic                 ready;
  lhbp_pkg::op_t        op;
  lhbp_pkg::addr_t      branch_address_low;
  logic                 taken;

  modport source (output valid, output op, output branch_address_low, output taken,
                  input ready);
  modport sink   (input valid, input op, input branch_address_low, input taken,
                  output ready);
endinterface

// response channel: prediction
interface lhbp_rsp_if;
  logic valid;
  logic ready;
  logic predict_taken;

  modport source (output valid, output predict_taken, input ready);
  modport sink   (input valid, input predict_taken, output ready);
endinterface

// configuration write channel
interface lhbp_cfg_if;
  logic              valid;
  logic              ready;
  lhbp_pkg::thresh_t taken_threshold;

  modport source (output valid, output taken_threshold, input ready);
  modport sink   (input valid, input taken_threshold, output ready);
endinterface

/* design/lhbp_ram.sv */
module lhbp_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 14
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

/* design/lhbp_ctrl.sv */
module lhbp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  lhbp_pkg::thresh_t     threshold,
  lhbp_req_if.sink              req,
  lhbp_rsp_if.source            rsp,
  input  lhbp_pkg::hist_t       hist_rdata,
  input  lhbp_pkg::ctr_t        pat_rdata,
  output lhbp_pkg::hist_req_t   hist_req,
  output lhbp_pkg::pat_req_t    pat_req
);

  lhbp_pkg::state_t state, state_next;
  lhbp_pkg::clr_t   clr, clr_next;
  lhbp_pkg::op_t    op_q;
  logic             taken_q;
  lhbp_pkg::slot_t  slot_q;
  logic             out_valid;
  logic             out_taken;
  logic             load_out;
  logic             accept;
  logic             pred;

  assign accept = req.valid && req.ready;
  assign pred = lhbp_pkg::CMP_W'(pat_rdata) >= lhbp_pkg::CMP_W'(threshold);

  // state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lhbp_pkg::ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  // captured request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.op;
      taken_q <= req.taken;
      slot_q  <= lhbp_pkg::slot_of(req.branch_address_low);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_taken <= pred;
  end

  assign rsp.valid         = out_valid;
  assign rsp.predict_taken = out_taken;

  // next state and table accesses
  always_comb begin
    state_next = state;
    clr_next   = clr;
    hist_req   = '0;
    pat_req    = '0;
    load_out   = 1'b0;
    req.ready  = 1'b0;
    case (state)
      lhbp_pkg::ST_CLEAR: begin
        hist_req.wr_en   = 1'b1;
        hist_req.wr_addr = lhbp_pkg::INDEX_BITS'(clr);
        pat_req.wr_en    = 1'b1;
        pat_req.wr_addr  = lhbp_pkg::HISTORY_BITS'(clr);
        clr_next         = clr + lhbp_pkg::clr_t'(1);
        if (clr == '1) state_next = lhbp_pkg::ST_IDLE;
      end
      lhbp_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          hist_req.rd_en   = 1'b1;
          hist_req.rd_addr = lhbp_pkg::slot_of(req.branch_address_low);
          state_next       = lhbp_pkg::ST_HIST;
        end
      end
      lhbp_pkg::ST_HIST: begin
        pat_req.rd_en   = 1'b1;
        pat_req.rd_addr = hist_rdata;
        state_next      = lhbp_pkg::ST_PAT;
      end
      lhbp_pkg::ST_PAT: begin
        if (op_q == lhbp_pkg::OP_PREDICT) begin
          // wait for the output register to free up
          if (!out_valid || rsp.ready) begin
            load_out   = 1'b1;
            state_next = lhbp_pkg::ST_IDLE;
          end
        end else begin
          pat_req.wr_en    = 1'b1;
          pat_req.wr_addr  = hist_rdata;
          pat_req.wr_data  = lhbp_pkg::ctr_step(pat_rdata, taken_q);
          hist_req.wr_en   = 1'b1;
          hist_req.wr_addr = slot_q;
          hist_req.wr_data = {hist_rdata[lhbp_pkg::HISTORY_BITS-2:0], taken_q};
          state_next       = lhbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lhbp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/local_history_branch_predictor.sv */
// channel | dir | payload                             | beat
// req     | in  | op, branch_address_low[9:0], taken  | valid & ready
// rsp     | out | predict_taken                       | valid & ready
// cfg     | in  | taken_threshold[1:0]                | valid & ready
//
// each item steps through accept + history read, pattern read, then result
// load or counter/history write-back before the next request is taken; the
// serial history-then-pattern memory read chain sets this order.
// after reset a clearing pass zeroes both tables, one entry a cycle, over
// 2^14 = 16384 addresses; req.ready stays low during it, cfg is taken as ever.
// a predict waits in its last cycle while an earlier result is not yet taken.
module local_history_branch_predictor (
  input  logic        clk,
  input  logic        rst,
  lhbp_req_if.sink    req,
  lhbp_rsp_if.source  rsp,
  lhbp_cfg_if.sink    cfg
);

  lhbp_pkg::thresh_t   threshold;
  lhbp_pkg::hist_req_t hist_req;
  lhbp_pkg::pat_req_t  pat_req;
  lhbp_pkg::hist_t     hist_rdata;
  lhbp_pkg::ctr_t      pat_rdata;

  // threshold register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= lhbp_pkg::THRESHOLD_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.taken_threshold;
    end
  end

  // sequencer
  lhbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .threshold  (threshold),
    .req        (req),
    .rsp        (rsp),
    .hist_rdata (hist_rdata),
    .pat_rdata  (pat_rdata),
    .hist_req   (hist_req),
    .pat_req    (pat_req)
  );

  // local history table
  lhbp_ram #(
    .ADDR_BITS (lhbp_pkg::INDEX_BITS),
    .DATA_BITS (lhbp_pkg::HISTORY_BITS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_req.wr_en),
    .wr_addr (hist_req.wr_addr),
    .wr_data (hist_req.wr_data),
    .rd_en   (hist_req.rd_en),
    .rd_addr (hist_req.rd_addr),
    .rd_data (hist_rdata)
  );

  // pattern counter table
  lhbp_ram #(
    .ADDR_BITS (lhbp_pkg::HISTORY_BITS),
    .DATA_BITS (lhbp_pkg::COUNTER_WIDTH)
  ) u_pat_ram (
    .clk     (clk),
    .wr_en   (pat_req.wr_en),
    .wr_addr (pat_req.wr_addr),
    .wr_data (pat_req.wr_data),
    .rd_en   (pat_req.rd_en),
    .rd_addr (pat_req.rd_addr),
    .rd_data (pat_rdata)
  );

endmodule
